// ----- design/cldf_pkg.sv -----
// cldf_pkg: shared types, codes and header constants for the
// content-length message deframer; no dependencies
`default_nettype none

package cldf_pkg;

    // one stream request as it arrives
    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } t_cldf_in;

    // one result request
    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_valid;
        logic       message_end;
        logic [2:0] status;
    } t_cldf_out;

    // byte after classification by the front end
    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
        logic       is_cr;
        logic       is_lf;
        logic       is_blank;
        logic       is_sign;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
    } t_cldf_item;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_EOF_HEADER    = 3'd1,
        ST_UNKNOWN_FIELD = 3'd2,
        ST_NO_LENGTH     = 3'd3,
        ST_EOF_BODY      = 3'd4
    } t_status;

    // framing phase
    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } t_phase;

    // length number parser
    typedef enum logic [1:0] {
        NUM_BLANK  = 2'd0,
        NUM_SIGNED = 2'd1,
        NUM_DIGITS = 2'd2,
        NUM_DONE   = 2'd3
    } t_num_stage;

    // character codes
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    // header line prefix sizes and line position ceiling
    localparam logic [4:0] LEN_PREFIX_SIZE  = 5'd16;
    localparam logic [4:0] TYPE_PREFIX_SIZE = 5'd14;
    localparam logic [4:0] POS_LIMIT        = 5'd17;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // "Content-Length: "
    function automatic logic [7:0] len_prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = " ";
        endcase
        return c;
    endfunction

    // "Content-Type: "
    function automatic logic [7:0] type_prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "T";
            4'd9:    c = "y";
            4'd10:   c = "p";
            4'd11:   c = "e";
            4'd12:   c = ":";
            4'd13:   c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/cldf_front.sv -----
// cldf_front: accepts stream requests and classifies each byte
// depends on cldf_pkg
`default_nettype none

module cldf_front
    import cldf_pkg::*;
(
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_cldf_in   i_in_data,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_cldf_item      o_item
);

    // accept whenever the queue has room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // byte classification
    always_comb begin
        o_item          = '0;
        o_item.data     = i_in_data.byte_in;
        o_item.eoi      = i_in_data.end_of_input;
        o_item.is_cr    = (i_in_data.byte_in == CHR_CR);
        o_item.is_lf    = (i_in_data.byte_in == CHR_LF);
        o_item.is_blank = (i_in_data.byte_in == CHR_SPACE) || (i_in_data.byte_in == CHR_TAB);
        o_item.is_minus = (i_in_data.byte_in == CHR_MINUS);
        o_item.is_sign  = (i_in_data.byte_in == CHR_PLUS) || o_item.is_minus;
        o_item.is_digit = (i_in_data.byte_in >= CHR_ZERO) && (i_in_data.byte_in <= CHR_NINE);
        o_item.digit    = i_in_data.byte_in[3:0];
    end

endmodule

`default_nettype wire

// ----- design/cldf_queue.sv -----
// cldf_queue: two-entry queue of classified bytes between front and back
// depends on cldf_pkg
`default_nettype none

module cldf_queue
    import cldf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_cldf_item i_item,
    output logic            o_full,
    input  wire logic       i_pop,
    output logic            o_valid,
    output t_cldf_item      o_item
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_cldf_item            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0]       r_wr_ptr;
    logic [PtrW-1:0]       r_rd_ptr;
    logic [CntW-1:0]       r_count;

    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/cldf_back.sv -----
// cldf_back: header parser, body counter and output register
// depends on cldf_pkg
`default_nettype none

module cldf_back
    import cldf_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire t_cldf_item i_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_cldf_out       o_out_data
);

    localparam int WideW = LENGTH_BITS + 4;

    t_phase                 r_phase, n_phase;
    logic                   r_cr_seen, n_cr_seen;
    logic [4:0]             r_pos, n_pos;
    logic                   r_lmatch, n_lmatch;
    logic                   r_tmatch, n_tmatch;
    logic                   r_len_seen, n_len_seen;
    t_num_stage             r_stage, n_stage;
    logic                   r_neg, n_neg;
    logic [LENGTH_BITS-1:0] r_len_val, n_len_val;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic                   r_out_valid;
    t_cldf_out              r_out_data;

    logic                   out_free;
    logic                   emit;
    t_cldf_out              res;
    logic                   start_ln;
    logic                   start_msg;
    logic                   enter_body;
    logic [WideW-1:0]       scaled;
    logic [LENGTH_BITS-1:0] acc_next;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = i_q_valid && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // accumulator times ten plus digit, saturating
    always_comb begin
        scaled = (WideW'(r_rem) << 3) + (WideW'(r_rem) << 1) + WideW'(i_item.digit);
        if (|scaled[WideW-1:LENGTH_BITS]) begin
            acc_next = '1;
        end else begin
            acc_next = scaled[LENGTH_BITS-1:0];
        end
    end

    // framing state machine
    always_comb begin
        n_phase    = r_phase;
        n_cr_seen  = r_cr_seen;
        n_pos      = r_pos;
        n_lmatch   = r_lmatch;
        n_tmatch   = r_tmatch;
        n_len_seen = r_len_seen;
        n_stage    = r_stage;
        n_neg      = r_neg;
        n_len_val  = r_len_val;
        n_rem      = r_rem;
        emit       = 1'b0;
        res        = '0;
        start_ln   = 1'b0;
        start_msg  = 1'b0;
        enter_body = 1'b0;

        if (o_pop) begin
            unique case (r_phase)
                PH_BODY: begin
                    if (i_item.eoi) begin
                        emit            = 1'b1;
                        res.message_end = 1'b1;
                        res.status      = ST_EOF_BODY;
                        start_msg       = 1'b1;
                    end else begin
                        emit            = 1'b1;
                        res.body_byte   = i_item.data;
                        res.body_valid  = 1'b1;
                        res.message_end = (r_rem <= LENGTH_BITS'(1));
                        res.status      = ST_OK;
                        if (r_rem <= LENGTH_BITS'(1)) begin
                            start_msg = 1'b1;
                        end else begin
                            n_rem = r_rem - LENGTH_BITS'(1);
                        end
                    end
                end
                default: begin
                    if (i_item.eoi) begin
                        emit            = 1'b1;
                        res.message_end = 1'b1;
                        res.status      = ST_EOF_HEADER;
                        start_msg       = 1'b1;
                    end else if (!r_cr_seen && i_item.is_cr) begin
                        // first cr of the line is dropped
                        n_cr_seen = 1'b1;
                    end else if (!(r_cr_seen && i_item.is_lf)) begin
                        // ordinary line byte: prefix match and number parse
                        if (r_pos < LEN_PREFIX_SIZE) begin
                            if (i_item.data != len_prefix_char(r_pos[3:0])) begin
                                n_lmatch = 1'b0;
                            end
                        end else if (r_lmatch) begin
                            unique case (r_stage)
                                NUM_BLANK: begin
                                    if (i_item.is_blank) begin
                                        n_stage = NUM_BLANK;
                                    end else if (i_item.is_sign) begin
                                        n_neg   = i_item.is_minus;
                                        n_stage = NUM_SIGNED;
                                    end else if (i_item.is_digit) begin
                                        n_rem   = acc_next;
                                        n_stage = NUM_DIGITS;
                                    end else begin
                                        n_stage = NUM_DONE;
                                    end
                                end
                                NUM_SIGNED, NUM_DIGITS: begin
                                    if (i_item.is_digit) begin
                                        n_rem   = acc_next;
                                        n_stage = NUM_DIGITS;
                                    end else begin
                                        n_stage = NUM_DONE;
                                    end
                                end
                                default: begin
                                    n_stage = r_stage;
                                end
                            endcase
                        end
                        if ((r_pos < TYPE_PREFIX_SIZE)
                            && (i_item.data != type_prefix_char(r_pos[3:0]))) begin
                            n_tmatch = 1'b0;
                        end
                        if (r_pos < POS_LIMIT) begin
                            n_pos = r_pos + 5'd1;
                        end
                    end else if (r_pos == '0) begin
                        // empty line closes the header
                        if (!r_len_seen) begin
                            emit            = 1'b1;
                            res.message_end = 1'b1;
                            res.status      = ST_NO_LENGTH;
                            start_msg       = 1'b1;
                        end else if (r_len_val == '0) begin
                            emit            = 1'b1;
                            res.message_end = 1'b1;
                            res.status      = ST_OK;
                            start_msg       = 1'b1;
                        end else begin
                            start_msg  = 1'b1;
                            enter_body = 1'b1;
                        end
                    end else if (r_lmatch && (r_pos >= LEN_PREFIX_SIZE)) begin
                        // length line: negative gives zero
                        n_len_val  = r_neg ? '0 : r_rem;
                        n_len_seen = 1'b1;
                        start_ln   = 1'b1;
                    end else if (r_tmatch && (r_pos >= TYPE_PREFIX_SIZE)) begin
                        start_ln = 1'b1;
                    end else begin
                        emit            = 1'b1;
                        res.message_end = 1'b1;
                        res.status      = ST_UNKNOWN_FIELD;
                        start_msg       = 1'b1;
                    end
                end
            endcase
        end

        // new message clears the header summary
        if (start_msg) begin
            n_phase    = PH_HEADER;
            n_len_seen = 1'b0;
            n_len_val  = '0;
        end
        // new line clears line state
        if (start_msg || start_ln) begin
            n_cr_seen = 1'b0;
            n_pos     = '0;
            n_lmatch  = 1'b1;
            n_tmatch  = 1'b1;
            n_stage   = NUM_BLANK;
            n_neg     = 1'b0;
            n_rem     = '0;
        end
        // body countdown loads the committed length
        if (enter_body) begin
            n_phase = PH_BODY;
            n_rem   = r_len_val;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_cr_seen  <= 1'b0;
            r_pos      <= '0;
            r_lmatch   <= 1'b1;
            r_tmatch   <= 1'b1;
            r_len_seen <= 1'b0;
            r_stage    <= NUM_BLANK;
            r_neg      <= 1'b0;
            r_len_val  <= '0;
            r_rem      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_cr_seen  <= n_cr_seen;
            r_pos      <= n_pos;
            r_lmatch   <= n_lmatch;
            r_tmatch   <= n_tmatch;
            r_len_seen <= n_len_seen;
            r_stage    <= n_stage;
            r_neg      <= n_neg;
            r_len_val  <= n_len_val;
            r_rem      <= n_rem;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_pop && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_data <= res;
        end
    end

endmodule

`default_nettype wire

// ----- design/content_length_message_deframer_unit.sv -----
// content_length_message_deframer_unit: top level of the deframer
// depends on cldf_pkg, cldf_front, cldf_queue, cldf_back
`default_nettype none

// Splits a byte stream into header lines and message bodies framed by a
// "Content-Length: " header. One input byte is taken per clock cycle when
// the output side keeps up; a request enters a two-entry queue on acceptance
// and, once popped, its result, if any, is registered in the output register.
// Header bytes give no result; body bytes give one each, the last marked with
// message_end. Errors and empty messages give a single result with body_valid
// low. The length count is LENGTH_BITS wide and saturates at its top value;
// the per-byte decimal accumulate is the longest path.
module content_length_message_deframer_unit
    import cldf_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_cldf_in i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_cldf_out     o_out_data
);

    logic       q_full;
    logic       push;
    t_cldf_item front_item;
    logic       pop;
    logic       q_valid;
    t_cldf_item q_item;

    cldf_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_item     (front_item)
    );

    cldf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cldf_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
